>>> design/aff_pkg.sv
// Shared types, constants and fixed-point helpers of the affine texel address generator.
package aff_pkg;

  // Texture geometry; both texture sizes are powers of two.
  localparam int TEX_WIDTH       = 256;
  localparam int TEX_HEIGHT      = 256;
  localparam int BYTES_PER_TEXEL = 4;
  localparam int ROW_BYTES       = TEX_WIDTH * BYTES_PER_TEXEL;

  // Field and datapath widths.
  localparam int PIX_W   = 10;            // screen coordinate
  localparam int DX_W    = PIX_W + 1;     // centered coordinate, signed
  localparam int MAT_W   = 18;            // Q2.16 matrix entry
  localparam int Q_FRAC  = 16;
  localparam int PROD_W  = DX_W + MAT_W;  // coordinate times entry
  localparam int SUM_W   = PROD_W + 1;    // sum of two products
  localparam int UI_W    = SUM_W - Q_FRAC; // whole texels after truncation
  localparam int MPROD_W = 2 * MAT_W;     // entry times entry, Q4.32
  localparam int MSUM_W  = MPROD_W + 1;
  localparam int MRND_W  = MSUM_W + 1;    // sum plus rounding bias
  localparam int MRES_W  = MRND_W - Q_FRAC;
  localparam int ADDR_W  = 32;
  localparam int TEX_W   = 8;             // reported column and row bits
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [UI_W-1:0] COL_MASK = UI_W'(TEX_WIDTH - 1);
  localparam logic [UI_W-1:0] ROW_MASK = UI_W'(TEX_HEIGHT - 1);

  localparam logic signed [MAT_W-1:0] Q_ONE   = MAT_W'(65536);
  localparam logic signed [MAT_W-1:0] SAT_MAX = MAT_W'(131071);
  localparam logic signed [MAT_W-1:0] SAT_MIN = MAT_W'(-131072);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_A     = 3'd0,
    CFG_STEP_B     = 3'd1,
    CFG_STEP_C     = 3'd2,
    CFG_STEP_D     = 3'd3,
    CFG_IMAGE_BASE = 3'd4,
    CFG_CENTER_X   = 3'd5,
    CFG_CENTER_Y   = 3'd6
  } aff_cfg_idx_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] step_a;
    logic signed [MAT_W-1:0] step_b;
    logic signed [MAT_W-1:0] step_c;
    logic signed [MAT_W-1:0] step_d;
    logic [ADDR_W-1:0]       image_base;
    logic [PIX_W-1:0]        center_x;
    logic [PIX_W-1:0]        center_y;
  } aff_cfg_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] a;
    logic signed [MAT_W-1:0] b;
    logic signed [MAT_W-1:0] c;
    logic signed [MAT_W-1:0] d;
  } aff_mat_t;

  localparam aff_cfg_t CFG_RESET = '{
    step_a:     MAT_W'(64802),
    step_b:     MAT_W'(-3184),
    step_c:     MAT_W'(3184),
    step_d:     MAT_W'(64802),
    image_base: '0,
    center_x:   PIX_W'(320),
    center_y:   PIX_W'(240)
  };

  localparam aff_mat_t MAT_RESET = '{a: Q_ONE, b: '0, c: '0, d: Q_ONE};

  // Truncate a Q.16 sum toward zero: negative values get a bias of one LSB short of 1.0.
  function automatic logic [UI_W-1:0] trunc_q16(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] t;
    bias = s[SUM_W-1] ? SUM_W'((1 << Q_FRAC) - 1) : '0;
    t = s + bias;
    return t[SUM_W-1:Q_FRAC];
  endfunction

  // Round a Q.32 sum to Q.16 (half up) and saturate to one matrix entry.
  function automatic logic signed [MAT_W-1:0] round_sat(input logic signed [MSUM_W-1:0] s);
    logic signed [MRND_W-1:0] t;
    logic signed [MRES_W-1:0] r;
    t = MRND_W'(s) + MRND_W'(1 << (Q_FRAC - 1));
    r = t[MRND_W-1:Q_FRAC];
    if (r > MRES_W'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (r < MRES_W'(SAT_MIN)) begin
      return SAT_MIN;
    end else begin
      return r[MAT_W-1:0];
    end
  endfunction

endpackage

>>> design/aff_matrix.sv
// Display matrix state and its per-frame advance by the step matrix.
module aff_matrix import aff_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  aff_cfg_t cfg,
  input  logic     start,   // last pixel of a frame has taken its products
  output aff_mat_t mat,
  output logic     mat_wr   // matrix is written at the end of this cycle
);

  aff_mat_t mat_r;
  logic     upd_v_r;
  logic signed [MPROD_W-1:0] p_aa_r, p_bc_r, p_ab_r, p_bd_r;
  logic signed [MPROD_W-1:0] p_ca_r, p_dc_r, p_cb_r, p_dd_r;
  aff_mat_t mat_nxt;

  // Product registers, loaded on start: the eight products of the right multiplication.
  always_ff @(posedge clk) begin
    if (start) begin
      p_aa_r <= MPROD_W'(mat_r.a * cfg.step_a);
      p_bc_r <= MPROD_W'(mat_r.b * cfg.step_c);
      p_ab_r <= MPROD_W'(mat_r.a * cfg.step_b);
      p_bd_r <= MPROD_W'(mat_r.b * cfg.step_d);
      p_ca_r <= MPROD_W'(mat_r.c * cfg.step_a);
      p_dc_r <= MPROD_W'(mat_r.d * cfg.step_c);
      p_cb_r <= MPROD_W'(mat_r.c * cfg.step_b);
      p_dd_r <= MPROD_W'(mat_r.d * cfg.step_d);
    end
  end

  // Pairwise sums, rounding and saturation of the registered products.
  always_comb begin
    mat_nxt.a = round_sat(MSUM_W'(p_aa_r) + MSUM_W'(p_bc_r));
    mat_nxt.b = round_sat(MSUM_W'(p_ab_r) + MSUM_W'(p_bd_r));
    mat_nxt.c = round_sat(MSUM_W'(p_ca_r) + MSUM_W'(p_dc_r));
    mat_nxt.d = round_sat(MSUM_W'(p_cb_r) + MSUM_W'(p_dd_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r   <= MAT_RESET;
      upd_v_r <= 1'b0;
    end else begin
      upd_v_r <= start;
      if (upd_v_r) begin
        mat_r <= mat_nxt;
      end
    end
  end

  assign mat    = mat_r;
  assign mat_wr = upd_v_r;

endmodule

>>> design/aff_texel_path.sv
// Three-register pixel pipeline: input, coordinate products, texel address result.
module aff_texel_path import aff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aff_cfg_t              cfg,
  input  aff_mat_t              mat,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_x,
  input  logic [PIX_W-1:0]      in_y,
  input  logic                  in_last,
  output logic                  last_fire,  // last pixel leaves the input register
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_addr,
  output logic [TEX_W-1:0]      out_col,
  output logic [TEX_W-1:0]      out_row
);

  logic                    s1_v_r, s1_last_r;
  logic [PIX_W-1:0]        s1_x_r, s1_y_r;
  logic                    s2_v_r;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic                    o_v_r;
  logic [ADDR_W-1:0]       o_addr_r;
  logic [TEX_W-1:0]        o_col_r, o_row_r;

  logic o_adv, s2_adv, s1_adv;
  logic signed [DX_W-1:0] dx, dy;
  logic [UI_W-1:0] u, v, col, row;
  logic [ADDR_W-1:0] addr_nxt;

  // Each stage moves when its successor is empty or moving.
  assign o_adv  = !o_v_r || out_ready;
  assign s2_adv = !s2_v_r || o_adv;
  assign s1_adv = !s1_v_r || s2_adv;
  assign in_ready  = s1_adv;
  assign last_fire = s1_v_r && s1_last_r && s2_adv;

  // Centered coordinates.
  assign dx = DX_W'({1'b0, s1_x_r}) - DX_W'({1'b0, cfg.center_x});
  assign dy = DX_W'({1'b0, s1_y_r}) - DX_W'({1'b0, cfg.center_y});

  // Truncate, wrap to the texture and form the byte address.
  always_comb begin
    u = trunc_q16(SUM_W'(pa_r) + SUM_W'(pb_r));
    v = trunc_q16(SUM_W'(pc_r) + SUM_W'(pd_r));
    col = u & COL_MASK;
    row = v & ROW_MASK;
    addr_nxt = cfg.image_base
             + ADDR_W'(ADDR_W'(row) * ADDR_W'(ROW_BYTES))
             + ADDR_W'(ADDR_W'(col) * ADDR_W'(BYTES_PER_TEXEL));
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
      s1_last_r <= in_last;
    end
    if (s2_adv) begin
      pa_r <= PROD_W'(dx * mat.a);
      pb_r <= PROD_W'(dy * mat.b);
      pc_r <= PROD_W'(dx * mat.c);
      pd_r <= PROD_W'(dy * mat.d);
    end
    if (o_adv) begin
      o_addr_r <= addr_nxt;
      o_col_r  <= col[TEX_W-1:0];
      o_row_r  <= row[TEX_W-1:0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (o_adv) begin
        o_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_addr  = o_addr_r;
  assign out_col   = o_col_r;
  assign out_row   = o_row_r;

endmodule

>>> design/affine_texel_address_generator.sv
// Top level of the affine texel address generator: configuration registers and stream ports.
// A pixel passes through the input, product and result registers on its way to out_.
// Throughput: one pixel per cycle while the output does not stall; after a pixel marked tlast
// the input pauses until the new matrix is in place: the matrix products are taken as that pixel leaves the
// input register, and the new matrix is summed in the cycle that accepts the next pixel.
// Reset (rst_n low, synchronous) empties the pipeline, sets the display matrix to identity
// and loads the step matrix, image base and screen center with their default values.
module affine_texel_address_generator import aff_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Pixel input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // pixel_x [9:0], pixel_y [19:10], zeros [23:20]
  input  logic                   in_tlast,   // frame_last
  // Texel address stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // texel_address [31:0], tex_col [39:32],
                                             // tex_row [47:40]
);

  aff_cfg_t cfg_r;
  logic     hold_r;
  aff_mat_t mat;
  logic     mat_wr;
  logic     path_ready;
  logic     last_fire;
  logic     in_fire;
  logic [ADDR_W-1:0] out_addr;
  logic [TEX_W-1:0]  out_col, out_row;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (aff_cfg_idx_t'(cfg_index))
        CFG_STEP_A:     cfg_r.step_a     <= cfg_wdata[MAT_W-1:0];
        CFG_STEP_B:     cfg_r.step_b     <= cfg_wdata[MAT_W-1:0];
        CFG_STEP_C:     cfg_r.step_c     <= cfg_wdata[MAT_W-1:0];
        CFG_STEP_D:     cfg_r.step_d     <= cfg_wdata[MAT_W-1:0];
        CFG_IMAGE_BASE: cfg_r.image_base <= cfg_wdata[ADDR_W-1:0];
        CFG_CENTER_X:   cfg_r.center_x   <= cfg_wdata[PIX_W-1:0];
        CFG_CENTER_Y:   cfg_r.center_y   <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off new pixels from the end of a frame until the new matrix is in place.
  assign in_tready = path_ready && (!hold_r || mat_wr);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      hold_r <= 1'b1;
    end else if (mat_wr) begin
      hold_r <= 1'b0;
    end
  end

  aff_texel_path u_path (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mat       (mat),
    .in_valid  (in_tvalid && !(hold_r && !mat_wr)),
    .in_ready  (path_ready),
    .in_x      (in_tdata[PIX_W-1:0]),
    .in_y      (in_tdata[2*PIX_W-1:PIX_W]),
    .in_last   (in_tlast),
    .last_fire (last_fire),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (out_addr),
    .out_col   (out_col),
    .out_row   (out_row)
  );

  aff_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .start  (last_fire),
    .mat    (mat),
    .mat_wr (mat_wr)
  );

  assign out_tdata = {out_row, out_col, out_addr};

  // A pixel that ends a frame always blocks the next one until the matrix advances.
  a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> hold_r)
    else $error("hold not raised after last pixel of frame");

  // The matrix is only rewritten as part of a pending frame advance.
  a_wr_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mat_wr |-> hold_r)
    else $error("matrix written without a pending frame advance");

  // Outside an advance the display matrix does not move.
  a_mat_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !mat_wr |=> $stable(mat))
    else $error("display matrix changed outside an advance");

  // The advance starts only from a held state.
  a_start_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    last_fire |-> hold_r)
    else $error("matrix advance started without a frame end");

endmodule

>>> verif/affine_texel_address_generator_test.sv
// Self-checking testbench: pixel streams through the texel address generator vs. a predictor.
`timescale 1ns / 100ps

module affine_texel_address_generator_test;
  import aff_pkg::*;

  // One texel address result, laid out as on out_tdata (lowest field last).
  typedef struct packed {
    logic [TEX_W-1:0]  tex_row;
    logic [TEX_W-1:0]  tex_col;
    logic [ADDR_W-1:0] texel_address;
  } texel_t;

  // One row of the directed pixel table; want is used only where has_want is set.
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             has_want;
    texel_t           want;
  } pixel_case_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_BURSTY
  } ready_mode_t;

  // The configuration port accepts this index, but no register sits behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam longint ENTRY_MAX = 131071;
  localparam longint ENTRY_MIN = -131072;

  localparam int N_PHASES         = 7;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int SETTLE_CYCLES    = 6;
  localparam int N_DIRECTED       = 20;

  // Directed pixels. Rows with a typed result run with the reset settings and the
  // identity display matrix (center 320/240, base 0); fields are row, column, address.
  localparam pixel_case_t DIRECTED_PIXELS [N_DIRECTED] = '{
    '{10'd320,  10'd240,  1'b0, 1'b1, '{8'd0,   8'd0,   32'd0}},
    '{10'd0,    10'd0,    1'b0, 1'b1, '{8'd16,  8'd192, 32'd17152}},
    '{10'd1023, 10'd1023, 1'b0, 1'b1, '{8'd15,  8'd191, 32'd16124}},
    '{10'd1023, 10'd0,    1'b0, 1'b1, '{8'd16,  8'd191, 32'd17148}},
    '{10'd0,    10'd1023, 1'b0, 1'b1, '{8'd15,  8'd192, 32'd16128}},
    '{10'd321,  10'd241,  1'b0, 1'b1, '{8'd1,   8'd1,   32'd1028}},
    '{10'd319,  10'd239,  1'b0, 1'b1, '{8'd255, 8'd255, 32'd262140}},
    '{10'd575,  10'd495,  1'b0, 1'b1, '{8'd255, 8'd255, 32'd262140}},
    '{10'd576,  10'd496,  1'b0, 1'b1, '{8'd0,   8'd0,   32'd0}},
    '{10'd682,  10'd341,  1'b0, 1'b1, '{8'd101, 8'd106, 32'd103848}},
    '{10'd341,  10'd682,  1'b0, 1'b1, '{8'd186, 8'd21,  32'd190548}},
    '{10'd320,  10'd240,  1'b1, 1'b1, '{8'd0,   8'd0,   32'd0}},
    '{10'd0,    10'd0,    1'b0, 1'b0, '0},
    '{10'd1023, 10'd1023, 1'b0, 1'b0, '0},
    '{10'd1023, 10'd0,    1'b1, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b1, 1'b0, '0},
    '{10'd512,  10'd512,  1'b1, 1'b0, '0},
    '{10'd100,  10'd900,  1'b0, 1'b0, '0},
    '{10'd319,  10'd239,  1'b0, 1'b0, '0},
    '{10'd1023, 10'd1023, 1'b1, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predictor copy of the registers and the display matrix, at their reset values.
  logic signed [MAT_W-1:0] step_a = 18'sd64802;
  logic signed [MAT_W-1:0] step_b = -18'sd3184;
  logic signed [MAT_W-1:0] step_c = 18'sd3184;
  logic signed [MAT_W-1:0] step_d = 18'sd64802;
  logic [ADDR_W-1:0]       tex_base = '0;
  logic [PIX_W-1:0]        ctr_x = 10'd320;
  logic [PIX_W-1:0]        ctr_y = 10'd240;
  logic signed [MAT_W-1:0] disp_a = 18'sd65536;
  logic signed [MAT_W-1:0] disp_b = '0;
  logic signed [MAT_W-1:0] disp_c = '0;
  logic signed [MAT_W-1:0] disp_d = 18'sd65536;

  texel_t pending_texels[$];
  int     error_count = 0;
  int     burst_left = 0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned ready_cycle = 0;
  int unsigned stall_left = 0;

  affine_texel_address_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncate a Q.16 value toward zero.
  function automatic longint toward_zero_q16(longint s);
    return (s >= 0) ? (s >>> Q_FRAC) : -((-s) >>> Q_FRAC);
  endfunction

  // Round a Q.32 value to Q.16 with ties upward, then clamp to one matrix entry.
  function automatic logic signed [MAT_W-1:0] round_q16_sat(longint s);
    longint r;
    r = (s + (longint'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
    if (r > ENTRY_MAX) begin
      r = ENTRY_MAX;
    end else if (r < ENTRY_MIN) begin
      r = ENTRY_MIN;
    end
    return MAT_W'(r);
  endfunction

  // Track a register write; only the low bits of each register count.
  function automatic void note_register_write(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_STEP_A: step_a = val[MAT_W-1:0];
      CFG_STEP_B: step_b = val[MAT_W-1:0];
      CFG_STEP_C: step_c = val[MAT_W-1:0];
      CFG_STEP_D: step_d = val[MAT_W-1:0];
      CFG_IMAGE_BASE: tex_base = val;
      CFG_CENTER_X: ctr_x = val[PIX_W-1:0];
      CFG_CENTER_Y: ctr_y = val[PIX_W-1:0];
      default: ;
    endcase
  endfunction

  // Map one pixel to its texel address, then advance the display matrix at frame end.
  function automatic texel_t map_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                       logic last);
    longint dx;
    longint dy;
    longint u;
    longint v;
    logic signed [MAT_W-1:0] na;
    logic signed [MAT_W-1:0] nb;
    logic signed [MAT_W-1:0] nc;
    logic signed [MAT_W-1:0] nd;
    texel_t t;
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    u = toward_zero_q16(dx * longint'(disp_a) + dy * longint'(disp_b));
    v = toward_zero_q16(dx * longint'(disp_c) + dy * longint'(disp_d));
    u = u & longint'(TEX_WIDTH - 1);
    v = v & longint'(TEX_HEIGHT - 1);
    t.texel_address = tex_base + ADDR_W'(v * ROW_BYTES) + ADDR_W'(u * BYTES_PER_TEXEL);
    t.tex_col = u[TEX_W-1:0];
    t.tex_row = v[TEX_W-1:0];
    if (last) begin
      na = round_q16_sat(longint'(disp_a) * longint'(step_a) +
                         longint'(disp_b) * longint'(step_c));
      nb = round_q16_sat(longint'(disp_a) * longint'(step_b) +
                         longint'(disp_b) * longint'(step_d));
      nc = round_q16_sat(longint'(disp_c) * longint'(step_a) +
                         longint'(disp_d) * longint'(step_c));
      nd = round_q16_sat(longint'(disp_c) * longint'(step_b) +
                         longint'(disp_d) * longint'(step_d));
      disp_a = na;
      disp_b = nb;
      disp_c = nc;
      disp_d = nd;
    end
    return t;
  endfunction

  // Random screen coordinate: mostly uniform, some at the edges, some around the center.
  function automatic logic [PIX_W-1:0] pick_coord(logic [PIX_W-1:0] center);
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
      1: return center + PIX_W'($urandom_range(0, 4)) - PIX_W'(2);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Register write, issued from a falling edge; the block takes it at the next rising edge.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    note_register_write(idx, val);
  endtask

  // Offer one pixel and hold it until the transaction completes; returns at a falling edge.
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic last,
                            logic has_want, texel_t want);
    texel_t predicted;
    in_tvalid = 1'b1;
    in_tdata = {{(IN_DATA_W - 2 * PIX_W){1'b0}}, py, px};
    in_tlast = last;
    @(posedge clk);
    while (in_tready !== 1'b1) begin
      @(posedge clk);
    end
    predicted = map_pixel(px, py, last);
    pending_texels.push_back(has_want ? want : predicted);
    @(negedge clk);
  endtask

  // Sender pacing: bursts of back-to-back pixels, separated by idle gaps with junk data.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid = 1'b0;
      in_tdata = IN_DATA_W'($urandom);
      in_tlast = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // Random frames: mostly several pixels long, now and then one or two, so frame ends
  // also come back to back.
  task automatic run_random_pixels(int count);
    int frame_left;
    frame_left = 0;
    for (int n = 0; n < count; n++) begin
      if (frame_left == 0) begin
        frame_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(4, 40);
      end
      send_pixel(pick_coord(ctr_x), pick_coord(ctr_y), frame_left == 1, 1'b0, '0);
      frame_left--;
      pace_sender();
    end
  endtask

  // Stop sending and wait until every result is back and the matrix update has finished.
  task automatic settle_pipeline();
    in_tvalid = 1'b0;
    while (pending_texels.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register settings per phase; in some writes the upper bits above the register's width carry junk.
  task automatic configure_phase(int phase);
    case (phase)
      2: begin
        // Step entries of largest magnitude: the matrix grows into saturation.
        write_register(CFG_IDX_UNUSED, $urandom);
        write_register(CFG_STEP_A, {14'($urandom), 18'h1FFFF});
        write_register(CFG_STEP_B, {14'($urandom), 18'h1FFFF});
        write_register(CFG_STEP_C, {14'($urandom), 18'h20000});
        write_register(CFG_STEP_D, {14'($urandom), 18'h1FFFF});
        write_register(CFG_IMAGE_BASE, 32'hFFFF_FFFF);
        write_register(CFG_CENTER_X, {22'($urandom), 10'h3FF});
        write_register(CFG_CENTER_Y, {22'($urandom), 10'h000});
      end
      3: begin
        // Most negative diagonal: entries flip sign and stay saturated.
        write_register(CFG_STEP_A, {14'($urandom), 18'h20000});
        write_register(CFG_STEP_B, 32'h0);
        write_register(CFG_STEP_C, 32'h0);
        write_register(CFG_STEP_D, {14'($urandom), 18'h20000});
        write_register(CFG_IMAGE_BASE, 32'h0);
        write_register(CFG_CENTER_X, 32'h0);
        write_register(CFG_CENTER_Y, 32'h3FF);
      end
      4: begin
        // Small rotation close to unity scale.
        write_register(CFG_STEP_A, 32'($urandom_range(60000, 70000)));
        write_register(CFG_STEP_B, 32'(int'($urandom_range(0, 16000)) - 8000));
        write_register(CFG_STEP_C, 32'(int'($urandom_range(0, 16000)) - 8000));
        write_register(CFG_STEP_D, 32'($urandom_range(60000, 70000)));
        write_register(CFG_IMAGE_BASE, $urandom);
        write_register(CFG_CENTER_X, $urandom);
        write_register(CFG_CENTER_Y, $urandom);
      end
      6: begin
        // Zero step: the matrix collapses at the first frame end, then every pixel maps to texel zero.
        write_register(CFG_STEP_A, 32'h0);
        write_register(CFG_STEP_B, 32'h0);
        write_register(CFG_STEP_C, 32'h0);
        write_register(CFG_STEP_D, 32'h0);
        write_register(CFG_IMAGE_BASE, $urandom);
        write_register(CFG_CENTER_X, $urandom);
        write_register(CFG_CENTER_Y, $urandom);
      end
      default: begin
        write_register(CFG_STEP_A, $urandom);
        write_register(CFG_STEP_B, $urandom);
        write_register(CFG_STEP_C, $urandom);
        write_register(CFG_STEP_D, $urandom);
        write_register(CFG_IMAGE_BASE, $urandom);
        write_register(CFG_CENTER_X, $urandom);
        write_register(CFG_CENTER_Y, $urandom);
      end
    endcase
  endtask

  // Receiver back-pressure: one of four patterns, picked anew at random during the run.
  always @(negedge clk) begin
    ready_cycle++;
    if (ready_cycle % 97 == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= ($urandom_range(0, 99) < 60);
      READY_PERIODIC: out_tready <= (ready_cycle % 4 != 3);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 12);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_texels
    texel_t got;
    texel_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = texel_t'(out_tdata);
      if (pending_texels.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_texels.pop_front();
        if (got.texel_address !== want.texel_address) begin
          $display("%0t: texel_address mismatch, expected %h, got %h",
                   $time, want.texel_address, got.texel_address);
          error_count++;
        end
        if (got.tex_col !== want.tex_col) begin
          $display("%0t: tex_col mismatch, expected %0d, got %0d",
                   $time, want.tex_col, got.tex_col);
          error_count++;
        end
        if (got.tex_row !== want.tex_row) begin
          $display("%0t: tex_row mismatch, expected %0d, got %0d",
                   $time, want.tex_row, got.tex_row);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random pixels under several settings.
  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(DIRECTED_PIXELS[i].px, DIRECTED_PIXELS[i].py, DIRECTED_PIXELS[i].last,
                 DIRECTED_PIXELS[i].has_want, DIRECTED_PIXELS[i].want);
      pace_sender();
    end
    run_random_pixels(RANDOM_PER_PHASE - N_DIRECTED);
    for (int p = 1; p < N_PHASES; p++) begin
      settle_pipeline();
      configure_phase(p);
      run_random_pixels(RANDOM_PER_PHASE);
    end
    settle_pipeline();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
design/aff_pkg.sv
design/aff_matrix.sv
design/aff_texel_path.sv
design/affine_texel_address_generator.sv
verif/affine_texel_address_generator_test.sv
